[rtl/core/spn_pkg.sv]
`default_nettype none

package spn_pkg;

    typedef logic [31:0] t_key;
    typedef logic [15:0] t_block;
    typedef logic [3:0]  t_nibble;

    localparam int unsigned NumStages = 8;

    localparam t_nibble SBOX_FWD [16] = '{
        4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7
    };

    localparam t_nibble SBOX_INV [16] = '{
        4'd14, 4'd3,  4'd4,  4'd8,  4'd1,  4'd12, 4'd10, 4'd15,
        4'd7,  4'd13, 4'd9,  4'd6,  4'd11, 4'd2,  4'd0,  4'd5
    };

    // Source position, counted from one at the most significant bit.
    localparam logic [4:0] PERM_SRC [16] = '{
        5'd1, 5'd5, 5'd9,  5'd13, 5'd2, 5'd6, 5'd10, 5'd14,
        5'd3, 5'd7, 5'd11, 5'd15, 5'd4, 5'd8, 5'd12, 5'd16
    };

    function automatic t_block f_sub_fwd(input t_block x);
        t_block y;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic t_block f_sub_inv(input t_block x);
        t_block y;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic t_block f_perm(input t_block x);
        t_block     y;
        logic [3:0] src;
        for (int i = 0; i < 16; i++) begin
            src = 4'(PERM_SRC[i] - 5'd1);
            y[15 - i] = x[4'd15 - src];
        end
        return y;
    endfunction

    // Round key r is the 16-bit window starting at nibble r from the top.
    function automatic t_block f_round_key(input t_key key, input int r);
        return key[31 - 4*r -: 16];
    endfunction

endpackage

`default_nettype wire

[rtl/core/spn_in_if.sv]
`default_nettype none

interface spn_in_if;
    logic            valid;
    logic            ready;
    spn_pkg::t_key   cipher_key;
    spn_pkg::t_block plain_block;

    modport source (output valid, output cipher_key, output plain_block, input ready);
    modport sink   (input valid, input cipher_key, input plain_block, output ready);
endinterface

`default_nettype wire

[rtl/core/spn_out_if.sv]
`default_nettype none

interface spn_out_if;
    logic            valid;
    logic            ready;
    spn_pkg::t_block cipher_block;
    spn_pkg::t_block flipped_decrypt;

    modport source (output valid, output cipher_block, output flipped_decrypt, input ready);
    modport sink   (input valid, input cipher_block, input flipped_decrypt, output ready);
endinterface

`default_nettype wire

[rtl/core/spn_cipher_16bit_encrypt_decrypt.sv]
// Throughput: one beat per cycle while o_out.ready holds; each of the eight
// pipeline stages does one cipher round, four for encryption and four for the
// check decryption. A stall holds a stage only while the stage after it is full and held.
// Reset clears the stage valid bits; the data registers are not reset.
`default_nettype none

module spn_cipher_16bit_encrypt_decrypt (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spn_in_if.sink    i_in,
    spn_out_if.source o_out
);
    import spn_pkg::*;

    logic   r_valid [NumStages];
    t_key   r_key   [0:6];
    t_block r_w     [NumStages];
    t_block r_ct    [3:7];

    logic   w_adv   [NumStages];
    t_block n_w     [NumStages];

    always_comb begin
        w_adv[NumStages-1] = !r_valid[NumStages-1] || o_out.ready;
        for (int s = NumStages - 2; s >= 0; s--) begin
            w_adv[s] = !r_valid[s] || w_adv[s+1];
        end
    end

    assign n_w[0] = f_perm(f_sub_fwd(i_in.plain_block ^ f_round_key(i_in.cipher_key, 0)));
    assign n_w[1] = f_perm(f_sub_fwd(r_w[0] ^ f_round_key(r_key[0], 1)));
    assign n_w[2] = f_perm(f_sub_fwd(r_w[1] ^ f_round_key(r_key[1], 2)));
    assign n_w[3] = f_sub_fwd(r_w[2] ^ f_round_key(r_key[2], 3)) ^ f_round_key(r_key[2], 4);
    assign n_w[4] = f_perm(f_sub_inv(r_ct[3] ^ 16'h0001 ^ f_round_key(r_key[3], 4))
                           ^ f_round_key(r_key[3], 3));
    assign n_w[5] = f_perm(f_sub_inv(r_w[4]) ^ f_round_key(r_key[4], 2));
    assign n_w[6] = f_perm(f_sub_inv(r_w[5]) ^ f_round_key(r_key[5], 1));
    assign n_w[7] = f_sub_inv(r_w[6]) ^ f_round_key(r_key[6], 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NumStages; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_valid[0] <= i_in.valid;
            end
            for (int s = 1; s < NumStages; s++) begin
                if (w_adv[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_key[0] <= i_in.cipher_key;
        end
        for (int s = 1; s < 7; s++) begin
            if (w_adv[s]) begin
                r_key[s] <= r_key[s-1];
            end
        end
        for (int s = 0; s < NumStages; s++) begin
            if (w_adv[s] && s != 3) begin
                r_w[s] <= n_w[s];
            end
        end
        if (w_adv[3]) begin
            r_ct[3] <= n_w[3];
        end
        for (int s = 4; s < NumStages; s++) begin
            if (w_adv[s]) begin
                r_ct[s] <= r_ct[s-1];
            end
        end
    end

    assign i_in.ready            = w_adv[0];
    assign o_out.valid           = r_valid[NumStages-1];
    assign o_out.cipher_block    = r_ct[7];
    assign o_out.flipped_decrypt = r_w[NumStages-1];

    // r_w[3] is never loaded; the ciphertext lives in r_ct from stage three on.
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_valid[0])
        else $error("accepted beat did not enter the first stage");

    a_held_stage_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[5] && !w_adv[5]) |=> (r_valid[5] && $stable(r_w[5])))
        else $error("held stage lost or changed its beat");

    a_ct_carried : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[3] && w_adv[4]) |=> (r_valid[4] && r_ct[4] == $past(r_ct[3])))
        else $error("ciphertext not carried into the decryption half");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[6] && w_adv[6]) |-> w_adv[7])
        else $error("stage advanced into a full, held stage");

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import spn_pkg::*;

    typedef struct packed {
        t_key   key;
        t_block block;
    } t_plain_beat;

    typedef struct packed {
        t_block cipher;
        t_block flipped;
    } t_cipher_pair;

    localparam int unsigned RandomBeats = 1300;

    localparam logic [3:0] SubFwd [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam logic [3:0] SubInv [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    logic i_clk;
    logic i_rst_n;

    spn_in_if  plain_bus ();
    spn_out_if cipher_bus ();

    spn_cipher_16bit_encrypt_decrypt dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (plain_bus),
        .o_out   (cipher_bus)
    );

    t_plain_beat  plain_queue [$];
    t_cipher_pair cipher_queue [$];
    int unsigned  total_beats;
    int unsigned  beats_sent;
    int unsigned  error_count;

    function automatic t_block round_key(input t_key key, input int r);
        return t_block'(key >> (16 - 4 * r));
    endfunction

    function automatic t_block substitute(input t_block x, input bit inverse);
        t_block y;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = inverse ? SubInv[x[4*n +: 4]] : SubFwd[x[4*n +: 4]];
        end
        return y;
    endfunction

    // Bit i from the top takes bit 4*(i%4) + i/4 from the top: a 4x4 transpose.
    function automatic t_block transpose(input t_block x);
        t_block y;
        for (int i = 0; i < 16; i++) begin
            y[15 - i] = x[15 - (4 * (i % 4) + i / 4)];
        end
        return y;
    endfunction

    function automatic t_cipher_pair encrypt_and_check(input t_key key, input t_block plain);
        t_block       w;
        t_cipher_pair res;
        w = plain;
        for (int r = 0; r < 3; r++) begin
            w = transpose(substitute(w ^ round_key(key, r), 1'b0));
        end
        res.cipher = substitute(w ^ round_key(key, 3), 1'b0) ^ round_key(key, 4);
        w = res.cipher ^ 16'h0001 ^ round_key(key, 4);
        for (int r = 3; r > 0; r--) begin
            w = transpose(substitute(w, 1'b1) ^ round_key(key, r));
        end
        res.flipped = substitute(w, 1'b1) ^ round_key(key, 0);
        return res;
    endfunction

    function automatic int unsigned idle_percent(input bit receiver);
        if (beats_sent < total_beats / 3) begin
            return receiver ? 52 : 21;
        end else if (beats_sent < 2 * total_beats / 3) begin
            return receiver ? 21 : 52;
        end
        return 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : drive_plain
        t_plain_beat next_beat;
        if (!i_rst_n) begin
            plain_bus.valid <= 1'b0;
        end else begin
            if (plain_bus.valid && plain_bus.ready) begin
                cipher_queue.push_back(encrypt_and_check(plain_bus.cipher_key,
                                                         plain_bus.plain_block));
                beats_sent++;
            end
            if (!plain_bus.valid || plain_bus.ready) begin
                if (plain_queue.size() > 0 && $urandom_range(99) >= idle_percent(1'b0)) begin
                    next_beat = plain_queue.pop_front();
                    plain_bus.valid       <= 1'b1;
                    plain_bus.cipher_key  <= next_beat.key;
                    plain_bus.plain_block <= next_beat.block;
                end else begin
                    plain_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_cipher
        t_cipher_pair want;
        if (!i_rst_n) begin
            cipher_bus.ready <= 1'b0;
        end else begin
            if (cipher_bus.valid && cipher_bus.ready) begin
                if (cipher_queue.size() == 0) begin
                    $display("%0t: unexpected beat, actual cipher %h flipped %h", $time,
                             cipher_bus.cipher_block, cipher_bus.flipped_decrypt);
                    error_count++;
                end else begin
                    want = cipher_queue.pop_front();
                    if (cipher_bus.cipher_block !== want.cipher) begin
                        $display("%0t: cipher_block expected %h actual %h", $time,
                                 want.cipher, cipher_bus.cipher_block);
                        error_count++;
                    end
                    if (cipher_bus.flipped_decrypt !== want.flipped) begin
                        $display("%0t: flipped_decrypt expected %h actual %h", $time,
                                 want.flipped, cipher_bus.flipped_decrypt);
                        error_count++;
                    end
                end
            end
            cipher_bus.ready <= ($urandom_range(99) >= idle_percent(1'b1));
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        plain_bus.valid       = 1'b0;
        plain_bus.cipher_key  = '0;
        plain_bus.plain_block = '0;
        cipher_bus.ready      = 1'b0;
        beats_sent            = 0;
        error_count           = 0;

        plain_queue.push_back('{32'h0000_0000, 16'h0000});
        plain_queue.push_back('{32'h0000_0000, 16'hFFFF});
        plain_queue.push_back('{32'hFFFF_FFFF, 16'h0000});
        plain_queue.push_back('{32'hFFFF_FFFF, 16'hFFFF});
        plain_queue.push_back('{32'hA5A5_A5A5, 16'hAAAA});
        plain_queue.push_back('{32'h5A5A_5A5A, 16'h5555});
        plain_queue.push_back('{32'h0123_4567, 16'h89AB});
        plain_queue.push_back('{32'hFEDC_BA98, 16'h7654});
        for (int i = 0; i < 16; i += 5) begin
            plain_queue.push_back('{32'h0000_0000, t_block'(1 << i)});
        end
        plain_queue.push_back('{32'h0000_0001, 16'h0000});
        plain_queue.push_back('{32'h0000_0080, 16'h0000});
        plain_queue.push_back('{32'h0000_8000, 16'h0000});
        plain_queue.push_back('{32'h0001_0000, 16'h0000});
        plain_queue.push_back('{32'h0100_0000, 16'h0000});
        plain_queue.push_back('{32'h8000_0000, 16'h0000});
        // Same key twice in a row, with plaintexts one bit apart.
        plain_queue.push_back('{32'h3C3C_C3C3, 16'h1234});
        plain_queue.push_back('{32'h3C3C_C3C3, 16'h1235});

        for (int i = 0; i < RandomBeats; i++) begin
            plain_queue.push_back('{t_key'($urandom), t_block'($urandom)});
        end
        total_beats = plain_queue.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plain_queue.size() > 0 || plain_bus.valid) @(posedge i_clk);
        while (cipher_queue.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (error_count == 0) begin
            $display("[spn_cipher_16bit_encrypt_decrypt] OK");
        end else begin
            $display("[spn_cipher_16bit_encrypt_decrypt] ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[spn_cipher_16bit_encrypt_decrypt] ERROR");
        $finish;
    end

endmodule
